@@ src/lssr_pkg.sv @@
package lssr_pkg;

    // Command codes carried on the input channel.
    localparam logic [2:0] CMD_PUSH      = 3'd0;
    localparam logic [2:0] CMD_POP       = 3'd1;
    localparam logic [2:0] CMD_REMOVE    = 3'd2;
    localparam logic [2:0] CMD_GET       = 3'd3;
    localparam logic [2:0] CMD_ITER_RST  = 3'd4;
    localparam logic [2:0] CMD_ITER_NEXT = 3'd5;

    // Status codes carried on the result channel.
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_WAIT_VAL = 6'b000010,
        ST_SRCH     = 6'b000100,
        ST_SHIFT    = 6'b001000,
        ST_TOP_RD   = 6'b010000,
        ST_FINISH   = 6'b100000
    } state_t;

endpackage

@@ src/lifo_stack_search_remove_top.sv @@
// Each command walks the sequencer states in order: push, iterator reset and
// refused commands go to the top read and then finish; pop, get and iterator
// next first wait for the word from the registered-read RAM; remove scans down
// from the top, then shifts the words above a match down. One command is in
// flight at a time; the next is taken the cycle after the result is registered.
// Reset clears the count, the iterator and the output valid; RAM is not cleared.
module lifo_stack_search_remove_top
    import lssr_pkg::*;
    #(
        parameter int DEPTH      = 16,
        parameter int DATA_WIDTH = 32
    )
    (
        input  logic        aclk,
        input  logic        aresetn,
        input  logic        s_valid,
        output logic        s_ready,
        input  logic [2:0]  s_command,
        input  logic [31:0] s_data_value,
        input  logic [3:0]  s_index,
        output logic        m_valid,
        input  logic        m_ready,
        output logic [31:0] m_out_value,
        output logic [1:0]  m_status,
        output logic [4:0]  m_entry_count,
        output logic [31:0] m_top_value,
        output logic        m_is_empty
    );

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 4) ? CW : 4;

    state_t                state_reg, state_next;
    logic [2:0]            cmd_reg, cmd_next;
    logic [DATA_WIDTH-1:0] data_reg, data_next;
    logic [DATA_WIDTH-1:0] value_reg, value_next;
    logic [1:0]            status_reg, status_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         iter_reg, iter_next;
    logic [AW-1:0]         ptr_reg, ptr_next;
    logic [AW-1:0]         pos_reg, pos_next;

    logic                  m_valid_reg;
    logic [31:0]           m_out_value_reg;
    logic [1:0]            m_status_reg;
    logic [4:0]            m_entry_count_reg;
    logic [31:0]           m_top_value_reg;
    logic                  m_is_empty_reg;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic [63:0]           din_ext;
    logic [DATA_WIDTH-1:0] din;
    logic [63:0]           value_ext;
    logic [63:0]           top_ext;
    logic [15:0]           count_ext;
    logic [CMPW-1:0]       idx_x;
    logic [CMPW-1:0]       cnt_x;
    logic [CMPW-1:0]       get_x;
    logic [AW-1:0]         top_addr;
    logic [CW-1:0]         cnt_m1;
    logic                  is_empty;
    logic                  is_full;
    logic                  out_load;

    // Operand resizing between the port widths and the storage width.
    assign din_ext   = 64'(s_data_value);
    assign din       = din_ext[DATA_WIDTH-1:0];
    assign value_ext = 64'(value_reg);
    assign top_ext   = 64'(ram_rdata);
    assign count_ext = 16'(count_reg);
    assign idx_x     = CMPW'(s_index);
    assign cnt_x     = CMPW'(count_reg);
    assign get_x     = cnt_x - CMPW'(1) - idx_x;
    assign cnt_m1    = count_reg - CW'(1);
    assign top_addr  = cnt_m1[AW-1:0];
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == CW'(DEPTH));
    assign out_load  = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);

    lssr_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer: next-state, RAM access and compare logic.
    always_comb begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        data_next   = data_reg;
        value_next  = value_reg;
        status_next = status_reg;
        count_next  = count_reg;
        iter_next   = iter_reg;
        ptr_next    = ptr_reg;
        pos_next    = pos_reg;
        ram_we      = 1'b0;
        ram_waddr   = ptr_reg;
        ram_wdata   = ram_rdata;
        ram_raddr   = top_addr;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next    = s_command;
                    data_next   = din;
                    value_next  = '0;
                    status_next = STAT_OK;
                    state_next  = ST_TOP_RD;
                    unique case (s_command)
                        CMD_PUSH: begin
                            if (is_full) begin
                                status_next = STAT_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[AW-1:0];
                                ram_wdata  = din;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        CMD_POP: begin
                            if (is_empty) begin
                                status_next = STAT_MISS;
                            end else begin
                                state_next = ST_WAIT_VAL;
                            end
                        end
                        CMD_REMOVE: begin
                            if (is_empty) begin
                                status_next = STAT_MISS;
                            end else begin
                                ptr_next   = top_addr;
                                state_next = ST_SRCH;
                            end
                        end
                        CMD_GET: begin
                            if (idx_x >= cnt_x) begin
                                status_next = STAT_MISS;
                            end else begin
                                ram_raddr  = get_x[AW-1:0];
                                state_next = ST_WAIT_VAL;
                            end
                        end
                        CMD_ITER_RST: begin
                            iter_next = count_reg;
                        end
                        CMD_ITER_NEXT: begin
                            if (iter_reg == '0 || iter_reg > count_reg) begin
                                status_next = STAT_MISS;
                            end else begin
                                ram_raddr  = AW'(iter_reg - CW'(1));
                                state_next = ST_WAIT_VAL;
                            end
                        end
                        default: begin
                            status_next = STAT_MISS;
                        end
                    endcase
                end
            end

            // The read issued at the transfer returns the requested word.
            ST_WAIT_VAL: begin
                value_next = ram_rdata;
                state_next = ST_TOP_RD;
                unique case (cmd_reg)
                    CMD_POP: begin
                        count_next = cnt_m1;
                        if (iter_reg > CW'(top_addr)) begin
                            iter_next = iter_reg - CW'(1);
                        end
                    end
                    CMD_ITER_NEXT: begin
                        iter_next = iter_reg - CW'(1);
                    end
                    default: begin
                    end
                endcase
            end

            // Scan from the top down, one entry compared per cycle.
            ST_SRCH: begin
                if (ram_rdata == data_reg) begin
                    if (ptr_reg == top_addr) begin
                        count_next = cnt_m1;
                        if (iter_reg > CW'(ptr_reg)) begin
                            iter_next = iter_reg - CW'(1);
                        end
                        state_next = ST_TOP_RD;
                    end else begin
                        ram_raddr  = ptr_reg + AW'(1);
                        pos_next   = ptr_reg;
                        state_next = ST_SHIFT;
                    end
                end else if (ptr_reg == '0) begin
                    status_next = STAT_MISS;
                    state_next  = ST_TOP_RD;
                end else begin
                    ram_raddr = ptr_reg - AW'(1);
                    ptr_next  = ptr_reg - AW'(1);
                end
            end

            // Move each word above the removed one down by one slot.
            ST_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
                ram_wdata = ram_rdata;
                ram_raddr = ptr_reg + AW'(2);
                if (ptr_reg + AW'(1) == top_addr) begin
                    count_next = cnt_m1;
                    if (iter_reg > CW'(pos_reg)) begin
                        iter_next = iter_reg - CW'(1);
                    end
                    state_next = ST_TOP_RD;
                end else begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end

            // The default read address is the current top slot.
            ST_TOP_RD: begin
                state_next = ST_FINISH;
            end

            ST_FINISH: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and working registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            iter_reg  <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            iter_reg  <= iter_next;
        end
        cmd_reg    <= cmd_next;
        data_reg   <= data_next;
        value_reg  <= value_next;
        status_reg <= status_next;
        ptr_reg    <= ptr_next;
        pos_reg    <= pos_next;
    end

    // Output register; it holds a result until its transfer completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (out_load) begin
            m_out_value_reg   <= value_ext[31:0];
            m_status_reg      <= status_reg;
            m_entry_count_reg <= count_ext[4:0];
            m_top_value_reg   <= is_empty ? 32'd0 : top_ext[31:0];
            m_is_empty_reg    <= is_empty;
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_out_value   = m_out_value_reg;
    assign m_status      = m_status_reg;
    assign m_entry_count = m_entry_count_reg;
    assign m_top_value   = m_top_value_reg;
    assign m_is_empty    = m_is_empty_reg;

endmodule

@@ src/lssr_ram.sv @@
module lssr_ram
    #(
        parameter int WIDTH = 32,
        parameter int DEPTH = 16
    )
    (
        input  logic                     aclk,
        input  logic                     we,
        input  logic [$clog2(DEPTH)-1:0] waddr,
        input  logic [WIDTH-1:0]         wdata,
        input  logic [$clog2(DEPTH)-1:0] raddr,
        output logic [WIDTH-1:0]         rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one read port with registered read data.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/lssr_checker.sv @@
module lssr_assert
    import lssr_pkg::*;
    (
        input logic        aclk,
        input logic        aresetn,
        input logic        s_valid,
        input logic        s_ready,
        input logic        m_valid,
        input logic        m_ready,
        input logic [31:0] m_out_value,
        input logic [1:0]  m_status,
        input logic [4:0]  m_entry_count,
        input logic [31:0] m_top_value,
        input logic        m_is_empty
    );

    // Ready is low in the cycle after an input transfer.
    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready stayed high right after an input transfer");

    // An empty store reports no entries and a zero top word.
    a_empty_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_empty) |-> (m_entry_count == 5'd0 && m_top_value == 32'd0))
        else $error("empty flag disagrees with count or top word");

    // A failed or refused command returns no word.
    a_fail_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != STAT_OK) |-> (m_out_value == 32'd0))
        else $error("nonzero value with a failing status");

    // A refused push only happens on a nonempty store.
    a_full_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STAT_FULL) |-> !m_is_empty)
        else $error("full status reported with an empty store");

    // A stalled result holds its payload.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_out_value) && $stable(m_status)))
        else $error("result changed before its transfer");

endmodule

bind lifo_stack_search_remove_top lssr_assert u_lssr_assert (.*);

@@ sim/lssr_checker.sv @@
`timescale 1ns / 1ps

module lssr_checker
    import lssr_pkg::*;
    #(
        parameter int DEPTH = 16
    )
    (
        input  logic        aclk,
        input  logic        aresetn,
        input  logic        s_valid,
        input  logic        s_ready,
        input  logic [2:0]  s_command,
        input  logic [31:0] s_data_value,
        input  logic [3:0]  s_index,
        input  logic        m_valid,
        input  logic        m_ready,
        input  logic [31:0] m_out_value,
        input  logic [1:0]  m_status,
        input  logic [4:0]  m_entry_count,
        input  logic [31:0] m_top_value,
        input  logic        m_is_empty,
        output int          error_count,
        output int          pending_count
    );

    typedef struct packed {
        logic [31:0] out_value;
        logic [1:0]  status;
        logic [4:0]  entry_count;
        logic [31:0] top_value;
        logic        is_empty;
    } stack_reply_t;

    // Shadow copy of the stack: slot 0 is the bottom, slot count-1 the top.
    logic [31:0]  shadow_slots [DEPTH];
    int           shadow_count;
    int           shadow_iter;
    stack_reply_t awaited_replies [$];

    // Take one word out of the stack, close the gap and keep the iterator
    // on the same word (or the one just below a removed word).
    function automatic void drop_entry(input int pos);
        for (int i = pos; i + 1 < shadow_count; i++) begin
            shadow_slots[i] = shadow_slots[i + 1];
        end
        shadow_count--;
        if (shadow_iter > pos) begin
            shadow_iter--;
        end
    endfunction

    // Apply one command to the shadow stack and build the reply it causes.
    function automatic stack_reply_t apply_stack_command(
        input logic [2:0]  cmd,
        input logic [31:0] word,
        input logic [3:0]  idx
    );
        stack_reply_t reply;
        int           hit;
        reply        = '0;
        reply.status = STAT_OK;
        case (cmd)
            CMD_PUSH: begin
                if (shadow_count >= DEPTH) begin
                    reply.status = STAT_FULL;
                end else begin
                    shadow_slots[shadow_count] = word;
                    shadow_count++;
                end
            end
            CMD_POP: begin
                if (shadow_count == 0) begin
                    reply.status = STAT_MISS;
                end else begin
                    reply.out_value = shadow_slots[shadow_count - 1];
                    drop_entry(shadow_count - 1);
                end
            end
            CMD_REMOVE: begin
                // The search runs from the top down and stops at the first match.
                hit = -1;
                for (int i = shadow_count - 1; i >= 0 && hit < 0; i--) begin
                    if (shadow_slots[i] == word) begin
                        hit = i;
                    end
                end
                if (hit < 0) begin
                    reply.status = STAT_MISS;
                end else begin
                    drop_entry(hit);
                end
            end
            CMD_GET: begin
                if (int'(idx) >= shadow_count) begin
                    reply.status = STAT_MISS;
                end else begin
                    reply.out_value = shadow_slots[shadow_count - 1 - int'(idx)];
                end
            end
            CMD_ITER_RST: begin
                shadow_iter = shadow_count;
            end
            CMD_ITER_NEXT: begin
                if (shadow_iter == 0 || shadow_iter > shadow_count) begin
                    reply.status = STAT_MISS;
                end else begin
                    reply.out_value = shadow_slots[shadow_iter - 1];
                    shadow_iter--;
                end
            end
            default: begin
                reply.status = STAT_MISS;
            end
        endcase
        reply.entry_count = shadow_count[4:0];
        reply.top_value   = (shadow_count > 0) ? shadow_slots[shadow_count - 1] : 32'h0;
        reply.is_empty    = (shadow_count == 0);
        return reply;
    endfunction

    // Compare each result transfer with the oldest awaited reply, then
    // record the reply caused by any input transfer at the same edge.
    always @(posedge aclk) begin : watch_channels
        stack_reply_t seen;
        stack_reply_t want;
        if (!aresetn) begin
            shadow_count = 0;
            shadow_iter  = 0;
            error_count  = 0;
            awaited_replies.delete();
        end else begin
            if (m_valid && m_ready) begin
                seen = {m_out_value, m_status, m_entry_count, m_top_value, m_is_empty};
                if (awaited_replies.size() == 0) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("%0t: unexpected result value=%h status=%0d count=%0d top=%h empty=%b",
                                 $realtime, seen.out_value, seen.status, seen.entry_count,
                                 seen.top_value, seen.is_empty);
                    end
                end else begin
                    want = awaited_replies.pop_front();
                    if (want !== seen) begin
                        error_count++;
                        if (error_count <= 10) begin
                            $display("%0t: mismatch expected value=%h status=%0d count=%0d top=%h empty=%b",
                                     $realtime, want.out_value, want.status, want.entry_count,
                                     want.top_value, want.is_empty);
                            $display("%0t:          actual   value=%h status=%0d count=%0d top=%h empty=%b",
                                     $realtime, seen.out_value, seen.status, seen.entry_count,
                                     seen.top_value, seen.is_empty);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                awaited_replies.push_back(apply_stack_command(s_command, s_data_value, s_index));
            end
        end
        pending_count = awaited_replies.size();
    end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import lssr_pkg::*;

    // Command codes the block does not know.
    localparam logic [2:0] CMD_BAD_LO = 3'd6;
    localparam logic [2:0] CMD_BAD_HI = 3'd7;

    localparam int RANDOM_ITEMS    = 750;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int QUIET_LO        = 120;
    localparam int QUIET_HI        = 280;
    localparam int HOLD_OFF_AT     = 320;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_AT        = 450;
    localparam int TAIL_CYCLES     = 60;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_command;
    logic [31:0] s_data_value;
    logic [3:0]  s_index;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_out_value;
    logic [1:0]  m_status;
    logic [4:0]  m_entry_count;
    logic [31:0] m_top_value;
    logic        m_is_empty;

    int          error_count;
    int          pending_count;
    int          sent_count    = 0;
    int          cycle_count   = 0;
    bit          hold_off_done = 1'b0;
    logic [31:0] value_pool [8];

    lifo_stack_search_remove_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_data_value  (s_data_value),
        .s_index       (s_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_value   (m_out_value),
        .m_status      (m_status),
        .m_entry_count (m_entry_count),
        .m_top_value   (m_top_value),
        .m_is_empty    (m_is_empty)
    );

    lssr_checker stack_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_data_value  (s_data_value),
        .s_index       (s_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_value   (m_out_value),
        .m_status      (m_status),
        .m_entry_count (m_entry_count),
        .m_top_value   (m_top_value),
        .m_is_empty    (m_is_empty),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Random idle decision, switched off during the quiet window.
    function automatic bit idle_now();
        return (sent_count < QUIET_LO || sent_count >= QUIET_HI) &&
               ($urandom_range(0, 99) < 19);
    endfunction

    // Mostly words from a small pool so that removes find matches and
    // duplicates occur, otherwise any word.
    function automatic logic [31:0] pick_word(input int pool_pct);
        if ($urandom_range(0, 99) < pool_pct) begin
            return value_pool[$urandom_range(0, 7)];
        end
        return $urandom();
    endfunction

    // One input transfer; entered and left at a falling edge.
    task automatic send_item(input logic [2:0] cmd, input logic [31:0] word,
                             input logic [3:0] idx);
        while (idle_now()) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_command    = cmd;
        s_data_value = word;
        s_index      = idx;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
        sent_count++;
    endtask

    // Result side: random back-pressure plus one long hold-off.
    initial begin
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (!hold_off_done && sent_count >= HOLD_OFF_AT) begin
                m_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                hold_off_done = 1'b1;
            end else begin
                m_ready = !idle_now();
            end
        end
    end

    // Watchdog on the whole run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Stimulus and verdict.
    initial begin
        int          push_bias;
        int          pick;
        logic [2:0]  cmd;
        logic [31:0] word;
        logic [3:0]  idx;

        s_valid      = 1'b0;
        s_command    = CMD_PUSH;
        s_data_value = 32'h0;
        s_index      = 4'h0;
        aresetn      = 1'b0;
        push_bias    = 25;
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 8; i++) begin
            value_pool[i] = $urandom();
        end

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Commands on an empty stack, and the unknown codes.
        send_item(CMD_POP, 32'h0, 4'h0);
        send_item(CMD_REMOVE, 32'h0, 4'h0);
        send_item(CMD_GET, 32'h0, 4'h0);
        send_item(CMD_ITER_NEXT, 32'h0, 4'h0);
        send_item(CMD_BAD_LO, 32'h0, 4'h0);
        send_item(CMD_BAD_HI, 32'hFFFF_FFFF, 4'hF);

        // Fill the stack, with one duplicated word, then push onto a full stack.
        for (int i = 0; i < 16; i++) begin
            if (i == 0) begin
                word = 32'h0000_0000;
            end else if (i == 1) begin
                word = 32'hFFFF_FFFF;
            end else if (i == 9) begin
                word = 32'h5A00_0004;
            end else begin
                word = 32'h5A00_0000 | i;
            end
            send_item(CMD_PUSH, word, 4'h0);
        end
        send_item(CMD_PUSH, 32'h1234_5678, 4'h0);

        // Reads at both ends, then the iterator across a remove and a pop.
        send_item(CMD_GET, 32'h0, 4'hF);
        send_item(CMD_GET, 32'h0, 4'h0);
        send_item(CMD_ITER_RST, 32'h0, 4'h0);
        send_item(CMD_ITER_NEXT, 32'h0, 4'h0);
        send_item(CMD_REMOVE, 32'h5A00_0004, 4'h0);
        send_item(CMD_POP, 32'h0, 4'h0);
        send_item(CMD_ITER_NEXT, 32'h0, 4'h0);
        send_item(CMD_REMOVE, 32'h1234_5678, 4'h0);

        // Random part: push-heavy and drain-heavy stretches alternate so the
        // depth sweeps between empty and full.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                push_bias = (push_bias == 70) ? 25 : 70;
            end
            if (n == DRAIN_AT) begin
                s_valid = 1'b0;
                while (pending_count != 0) begin
                    @(negedge aclk);
                end
            end
            word = 32'h0;
            idx  = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3))
                                              : 4'($urandom_range(0, 15));
            if ($urandom_range(0, 99) < push_bias) begin
                cmd  = CMD_PUSH;
                word = pick_word(60);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 25) begin
                    cmd = CMD_POP;
                end else if (pick < 50) begin
                    cmd  = CMD_REMOVE;
                    word = pick_word(70);
                end else if (pick < 68) begin
                    cmd = CMD_GET;
                end else if (pick < 78) begin
                    cmd = CMD_ITER_RST;
                end else if (pick < 96) begin
                    cmd = CMD_ITER_NEXT;
                end else begin
                    cmd  = ($urandom_range(0, 1) == 0) ? CMD_BAD_LO : CMD_BAD_HI;
                    word = $urandom();
                end
            end
            send_item(cmd, word, idx);
        end
        s_valid = 1'b0;

        // Drain, then give the block time to show any stray result.
        while (pending_count != 0) begin
            @(negedge aclk);
        end
        repeat (TAIL_CYCLES) @(negedge aclk);

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ lifo_stack_search_remove_top.f @@
src/lssr_pkg.sv
src/lssr_ram.sv
src/lifo_stack_search_remove_top.sv
src/lssr_checker.sv
sim/lssr_checker.sv
sim/testbench.sv
